// File: hdl/ple_pkg.sv
// Shared types, codes and widths for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int LIST_DEPTH_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 7;
    localparam int CMP_W    = POS_W + 1;

    localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_TAIL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_POS  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DUMP     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic capture;
        logic exec;
        logic dump_step;
    } ple_ctl_t;

    typedef struct packed {
        logic is_dump;
        logic empty;
        logic out_free;
        logic dump_last;
    } ple_stat_t;

endpackage

`default_nettype wire

// File: hdl/ple_if.sv
// Valid/ready channel interfaces for command and response beats.
`default_nettype none

interface ple_cmd_if;
    import ple_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [POS_W-1:0]           position;
    logic signed [VAL_W-1:0]    value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface ple_rsp_if;
    import ple_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VAL_W-1:0]    element;
    logic                       last;
    logic [LENGTH_W-1:0]        length;

    modport source (output valid, output status, output element, output last, output length,
                    input ready);
    modport sink   (input valid, input status, input element, input last, input length,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/positional_list_engine_top.sv
// Insert and delete register their response beat in the execute state that follows acceptance.
// Dump of n values registers one value per cycle, while the response side is free, through a rotating
// cell chain in the dump state after the execute state; the next command is accepted once back in idle.
// One command at a time; the next is accepted while the last response beat still waits.
// Response backpressure stalls execution and dump steps cycle by cycle.
// Reset clears the length, the state machine and the response valid; cells need no clearing.
`default_nettype none

module positional_list_engine_top #(
    parameter int LIST_DEPTH = ple_pkg::LIST_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ple_cmd_if.sink    cmd,
    ple_rsp_if.source  rsp
);
    import ple_pkg::*;

    ple_ctl_t  ctl;
    ple_stat_t st;
    logic      ready;

    assign cmd.ready = ready;

    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (ready),
        .ctl       (ctl),
        .st        (st)
    );

    ple_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .action   (cmd.action),
        .position (cmd.position),
        .value    (cmd.value),
        .ctl      (ctl),
        .st       (st),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// File: hdl/ple_ctrl.sv
// Controller state machine sequencing capture, execute and dump beats.
`default_nettype none

module ple_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    output ple_pkg::ple_ctl_t      ctl,
    input  wire ple_pkg::ple_stat_t st
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } ple_state_t;

    ple_state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd_ready     = 1'b0;
        ctl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready   = 1'b1;
                ctl.capture = cmd_valid;
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st.out_free)
                begin
                    ctl.exec   = 1'b1;
                    state_next = (st.is_dump && !st.empty) ? S_DUMP : S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (st.out_free)
                begin
                    ctl.dump_step = 1'b1;
                    if (st.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ple_datapath.sv
// Cell chain, length counter, dump counter and response register.
`default_nettype none

module ple_datapath #(
    parameter int LIST_DEPTH = ple_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ple_pkg::ACTION_W-1:0]  action,
    input  wire logic [ple_pkg::POS_W-1:0]     position,
    input  wire logic signed [ple_pkg::VAL_W-1:0] value,
    input  wire ple_pkg::ple_ctl_t             ctl,
    output ple_pkg::ple_stat_t                 st,
    ple_rsp_if.source                          rsp
);
    import ple_pkg::*;

    localparam int LEN_W = $clog2(LIST_DEPTH + 1);

    logic [ACTION_W-1:0]     act_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;

    logic signed [VAL_W-1:0] cells_reg  [LIST_DEPTH];
    logic signed [VAL_W-1:0] cells_next [LIST_DEPTH];

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] dcnt_reg, dcnt_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic signed [VAL_W-1:0] out_elem_reg, out_elem_next;
    logic                    out_last_reg, out_last_next;
    logic [LENGTH_W-1:0]     out_len_reg, out_len_next;

    logic [CMP_W-1:0]    n_c, n_p1, pos_c, idx;
    logic                full, empty, do_ins, do_del, emit;
    logic [STATUS_W-1:0] res_status;
    logic                dump_last;

    assign n_c   = CMP_W'(len_reg);
    assign n_p1  = n_c + CMP_W'(1);
    assign pos_c = CMP_W'(pos_reg);
    assign full  = (n_c == CMP_W'(LIST_DEPTH));
    assign empty = (len_reg == '0);
    assign dump_last = ((CMP_W'(dcnt_reg) + CMP_W'(1)) == n_c);

    always_comb
    begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        emit       = 1'b0;
        idx        = '0;
        res_status = ST_OK;
        case (act_reg)
            ACT_INS_HEAD:
            begin
                emit = 1'b1;
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            ACT_INS_TAIL:
            begin
                emit = 1'b1;
                idx  = n_c;
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            ACT_INS_POS:
            begin
                emit = 1'b1;
                idx  = pos_c - CMP_W'(1);
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else if (pos_c == '0 || pos_c > n_p1)
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            ACT_DELETE:
            begin
                emit = 1'b1;
                idx  = pos_c - CMP_W'(1);
                if (empty)
                begin
                    res_status = ST_EMPTY;
                end
                else if (pos_c == '0 || pos_c > n_c)
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            ACT_DUMP:
            begin
                if (empty)
                begin
                    emit       = 1'b1;
                    res_status = ST_EMPTY;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    for (genvar gi = 0; gi < LIST_DEPTH; gi++)
    begin : g_cell
        localparam int PREV = (gi == 0) ? 0 : gi - 1;
        localparam int NEXT = (gi == LIST_DEPTH - 1) ? gi : gi + 1;
        localparam logic [CMP_W-1:0] POS_I = CMP_W'(gi);

        always_comb
        begin
            cells_next[gi] = cells_reg[gi];
            if (ctl.exec && do_ins)
            begin
                if (POS_I == idx)
                begin
                    cells_next[gi] = val_reg;
                end
                else if (POS_I > idx && POS_I <= n_c)
                begin
                    cells_next[gi] = cells_reg[PREV];
                end
            end
            else if (ctl.exec && do_del)
            begin
                if (POS_I >= idx && (POS_I + CMP_W'(1)) < n_c)
                begin
                    cells_next[gi] = cells_reg[NEXT];
                end
            end
            else if (ctl.dump_step)
            begin
                if ((POS_I + CMP_W'(1)) < n_c)
                begin
                    cells_next[gi] = cells_reg[NEXT];
                end
                else if ((POS_I + CMP_W'(1)) == n_c)
                begin
                    cells_next[gi] = cells_reg[0];
                end
            end
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (ctl.exec && do_ins)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (ctl.exec && do_del)
        begin
            len_next = len_reg - LEN_W'(1);
        end
    end

    always_comb
    begin
        dcnt_next = dcnt_reg;
        if (ctl.exec)
        begin
            dcnt_next = '0;
        end
        else if (ctl.dump_step)
        begin
            dcnt_next = dcnt_reg + LEN_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;
        out_len_next    = out_len_reg;
        if (ctl.exec && emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_elem_next   = '0;
            out_last_next   = 1'b1;
            out_len_next    = LENGTH_W'(len_next);
        end
        else if (ctl.dump_step)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_elem_next   = cells_reg[0];
            out_last_next   = dump_last;
            out_len_next    = LENGTH_W'(len_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            act_reg <= action;
            pos_reg <= position;
            val_reg <= value;
        end
        cells_reg      <= cells_next;
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_last_reg   <= out_last_next;
        out_len_reg    <= out_len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign st.is_dump   = (act_reg == ACT_DUMP);
    assign st.empty     = empty;
    assign st.out_free  = !out_valid_reg || rsp.ready;
    assign st.dump_last = dump_last;

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.element = out_elem_reg;
    assign rsp.last    = out_last_reg;
    assign rsp.length  = out_len_reg;

endmodule

`default_nettype wire

// File: hdl/ple_checker.sv
// Port-level checks on response beats, bound to the top level.
`default_nettype none

module ple_checker #(
    parameter int LIST_DEPTH = ple_pkg::LIST_DEPTH_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [ple_pkg::STATUS_W-1:0]      rsp_status,
    input wire logic signed [ple_pkg::VAL_W-1:0]  rsp_element,
    input wire logic                              rsp_last,
    input wire logic [ple_pkg::LENGTH_W-1:0]      rsp_length
);
    import ple_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped before taken");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_length <= LENGTH_W'(LIST_DEPTH))
        else $error("length beyond list depth");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_element == '0)
        else $error("error beat not a single zero-element beat");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_length == '0)
        else $error("empty status with nonzero length");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_length == LENGTH_W'(LIST_DEPTH))
        else $error("full status with list not full");

endmodule

bind positional_list_engine_top ple_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_ple_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_element (rsp.element),
    .rsp_last    (rsp.last),
    .rsp_length  (rsp.length)
);

`default_nettype wire
